/* hw/rtl/nbp_pkg.sv */
// nbp_pkg: shared types and codes for the nearest boundary projection unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package nbp_pkg;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam int CW = 24;
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] T_ONE = 17'h10000;

    typedef struct packed {
        logic [1:0] req_type;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
    } item_t;

    typedef struct packed {
        logic [5:0] edge_index;
        logic [16:0] edge_fraction;
        logic signed [CW-1:0] proj_x;
        logic signed [CW-1:0] proj_y;
        logic [49:0] dist_squared;
        logic polygon_empty;
        logic vertex_overflow;
    } result_t;

endpackage
`default_nettype wire

/* hw/rtl/nbp_queue.sv */
// nbp_queue: two-entry item queue between the front and back parts
// depends on nbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module nbp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire nbp_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output nbp_pkg::item_t       out_item
);

    nbp_pkg::item_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an item");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && push) |=> cnt_reg == 2'd1)
        else $error("push into empty queue lost");

endmodule
`default_nettype wire

/* hw/rtl/nbp_engine.sv */
// nbp_engine: vertex store and per-edge projection sequencer
// depends on nbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module nbp_engine #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire nbp_pkg::item_t   in_item,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output nbp_pkg::result_t      res_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA = 4'd1;
    localparam logic [3:0] S_RDB = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_SUM1 = 4'd4;
    localparam logic [3:0] S_DIV = 4'd5;
    localparam logic [3:0] S_PMUL = 4'd6;
    localparam logic [3:0] S_PADD = 4'd7;
    localparam logic [3:0] S_EMUL = 4'd8;
    localparam logic [3:0] S_CMP = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [47:0] vmem [MAX_VERTICES];
    logic [47:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic rd_en;

    logic [3:0] state_reg;
    logic [NW-1:0] count_reg;
    logic ovf_reg;
    logic [NW-1:0] j_reg;
    logic have_reg;
    logic signed [23:0] px_reg, py_reg, ax_reg, ay_reg;
    logic signed [24:0] dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [49:0] mxx_reg, myy_reg, mdx_reg, mdy_reg;
    logic [50:0] len_reg;
    logic signed [51:0] dot_reg;
    logic [51:0] rem_reg;
    logic [16:0] t_reg;
    logic [4:0] it_reg;
    logic signed [42:0] tx_reg, ty_reg;
    logic signed [25:0] qx_reg, qy_reg, ex_reg, ey_reg;
    logic [50:0] ex2_reg, ey2_reg;
    nbp_pkg::result_t best_reg;
    logic res_valid_reg;

    logic [NW-1:0] k_idx;
    logic [52:0] rem_sh;
    logic [49:0] dist_w;
    logic signed [42:0] rx, ry;
    logic signed [26:0] qx_w, qy_w;

    assign k_idx = (j_reg + 1'b1 < count_reg) ? j_reg + 1'b1 : '0;
    assign rd_en = (state_reg == S_RDA) || (state_reg == S_RDB);
    assign rd_addr = (state_reg == S_RDA) ? j_reg[AW-1:0] : k_idx[AW-1:0];
    assign in_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data = best_reg;
    assign rem_sh = {rem_reg, 1'b0};
    assign dist_w = ex2_reg[49:0] + ey2_reg[49:0];
    assign rx = tx_reg + 43'sd32768;
    assign ry = ty_reg + 43'sd32768;
    assign qx_w = 27'(ax_reg) + 27'(rx >>> 16);
    assign qy_w = 27'(ay_reg) + 27'(ry >>> 16);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_item.req_type == nbp_pkg::REQ_START)
        begin
            vmem[0] <= {in_item.coord_x, in_item.coord_y};
        end
        else if (in_valid && in_ready && in_item.req_type == nbp_pkg::REQ_APPEND
            && count_reg < NW'(MAX_VERTICES))
        begin
            vmem[count_reg[AW-1:0]] <= {in_item.coord_x, in_item.coord_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= vmem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                px_reg <= in_item.coord_x;
                py_reg <= in_item.coord_y;
            end
            S_RDB:
            begin
                ax_reg <= rd_data_reg[47:24];
                ay_reg <= rd_data_reg[23:0];
                wx_reg <= 25'(px_reg) - 25'(signed'(rd_data_reg[47:24]));
                wy_reg <= 25'(py_reg) - 25'(signed'(rd_data_reg[23:0]));
            end
            S_MUL1:
            begin
                dx_reg <= 25'(signed'(rd_data_reg[47:24])) - 25'(ax_reg);
                dy_reg <= 25'(signed'(rd_data_reg[23:0])) - 25'(ay_reg);
            end
            S_SUM1:
            begin
                mxx_reg <= dx_reg * dx_reg;
                myy_reg <= dy_reg * dy_reg;
                mdx_reg <= wx_reg * dx_reg;
                mdy_reg <= wy_reg * dy_reg;
            end
            S_DIV:
            begin
                if (it_reg == 5'd0)
                begin
                    len_reg <= 51'(mxx_reg) + 51'(myy_reg);
                    dot_reg <= 52'(mdx_reg) + 52'(mdy_reg);
                    rem_reg <= 52'(mdx_reg) + 52'(mdy_reg);
                    t_reg <= '0;
                end
                else if (it_reg == 5'd1)
                begin
                    if (len_reg == '0 || dot_reg <= 0)
                    begin
                        t_reg <= '0;
                    end
                    else if (dot_reg >= 52'(len_reg))
                    begin
                        t_reg <= nbp_pkg::T_ONE;
                    end
                end
                else
                begin
                    if (rem_sh >= 53'(len_reg))
                    begin
                        rem_reg <= 52'(rem_sh - 53'(len_reg));
                        t_reg <= {t_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[51:0];
                        t_reg <= {t_reg[15:0], 1'b0};
                    end
                end
            end
            S_PMUL:
            begin
                tx_reg <= 43'($signed({1'b0, t_reg}) * dx_reg);
                ty_reg <= 43'($signed({1'b0, t_reg}) * dy_reg);
            end
            S_PADD:
            begin
                qx_reg <= qx_w[25:0];
                qy_reg <= qy_w[25:0];
                ex_reg <= 26'(px_reg) - qx_w[25:0];
                ey_reg <= 26'(py_reg) - qy_w[25:0];
            end
            S_EMUL:
            begin
                ex2_reg <= 51'(ex_reg * ex_reg);
                ey2_reg <= 51'(ey_reg * ey_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            best_reg.edge_index <= '0;
            best_reg.edge_fraction <= '0;
            best_reg.proj_x <= '0;
            best_reg.proj_y <= '0;
            best_reg.dist_squared <= '0;
            best_reg.polygon_empty <= (count_reg == '0);
            best_reg.vertex_overflow <= ovf_reg;
        end
        else if (state_reg == S_CMP && (!have_reg || dist_w < best_reg.dist_squared))
        begin
            best_reg.edge_index <= 6'(j_reg);
            best_reg.edge_fraction <= t_reg;
            best_reg.proj_x <= qx_reg[23:0];
            best_reg.proj_y <= qy_reg[23:0];
            best_reg.dist_squared <= dist_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            j_reg <= '0;
            have_reg <= 1'b0;
            it_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        unique case (in_item.req_type)
                            nbp_pkg::REQ_START:
                            begin
                                count_reg <= NW'(1);
                            end
                            nbp_pkg::REQ_APPEND:
                            begin
                                if (count_reg < NW'(MAX_VERTICES))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            nbp_pkg::REQ_QUERY:
                            begin
                                j_reg <= '0;
                                have_reg <= 1'b0;
                                state_reg <= (count_reg == '0) ? S_OUT : S_RDA;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB: state_reg <= S_MUL1;
                S_MUL1: state_reg <= S_SUM1;
                S_SUM1:
                begin
                    it_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (it_reg == 5'd1 && (len_reg == '0 || dot_reg <= 0
                        || dot_reg >= 52'(len_reg)))
                    begin
                        state_reg <= S_PMUL;
                    end
                    else if (it_reg == 5'd17)
                    begin
                        state_reg <= S_PMUL;
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_PMUL: state_reg <= S_PADD;
                S_PADD: state_reg <= S_EMUL;
                S_EMUL: state_reg <= S_CMP;
                S_CMP:
                begin
                    have_reg <= 1'b1;
                    if (j_reg + 1'b1 >= count_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_RDA;
                    end
                end
                S_OUT:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> res_valid_reg)
        else $error("result not raised");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> j_reg < count_reg)
        else $error("edge index past count");

endmodule
`default_nettype wire

/* hw/rtl/nearest_boundary_projection_unit.sv */
// nearest_boundary_projection_unit: top level, queue in front of the projection engine
// depends on nbp_pkg, nbp_queue, nbp_engine
// usage:
//   s_axis carries items: type 0 starts a polygon with a vertex, 1 appends a
//   vertex, 2 queries a point, 3 is ignored. loads give no result, each query
//   gives one result item on m_axis.
//   a two-entry queue takes items while the engine works.
//   a load is taken by the engine in idle; a query walks each edge through the
//   states RDA, RDB, MUL1, SUM1, DIV, PMUL, PADD, EMUL and CMP, with up to 16
//   steps of the shared bit-serial divider, reading both edge vertices from the
//   single-port vertex memory; OUT then presents the result. no new item is taken while a query runs.
//   an empty polygon returns polygon_empty with other fields zero.
//   reset clears the vertex count and overflow flag; store contents are kept.
//   when m_axis stalls the result holds and the engine takes no new item;
//   the queue keeps accepting until full.
`timescale 1ns / 1ps
`default_nettype none
module nearest_boundary_projection_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // coord_x, coord_y
    input  wire logic [1:0]   s_axis_tuser,   // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // edge_index, edge_fraction, proj_x,
                                              // proj_y, dist_squared, 7 zero bits
    output logic [1:0]        m_axis_tuser    // polygon_empty, vertex_overflow
);

    nbp_pkg::item_t in_item, q_item;
    nbp_pkg::result_t res;
    logic q_valid, q_ready;

    assign in_item.req_type = s_axis_tuser;
    assign in_item.coord_x = s_axis_tdata[23:0];
    assign in_item.coord_y = s_axis_tdata[47:24];

    nbp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    nbp_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
    );

    assign m_axis_tdata = {7'd0, res.dist_squared, res.proj_y, res.proj_x,
                           res.edge_fraction, res.edge_index};
    assign m_axis_tuser = {res.vertex_overflow, res.polygon_empty};

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// tb: self-checking testbench for nearest_boundary_projection_unit
// depends on nbp_pkg and the unit's rtl; loads polygons, queries points, checks each result item
`timescale 1ns / 1ps
module tb;

    localparam int MAXV = 64;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    nearest_boundary_projection_unit #(.MAX_VERTICES(MAXV)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    typedef struct {
        logic [1:0] req;
        int x;
        int y;
        bit fixed;
        nbp_pkg::result_t res;
    } stim_row_t;

    longint poly_x [MAXV];
    longint poly_y [MAXV];
    int poly_count;
    bit poly_overflow;

    nbp_pkg::result_t pending_results[$];
    int mismatches;
    int items_sent;
    int queries_sent;
    int results_seen;
    bit hold_done;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // edge parameter, floor(d * 65536 / len2) for 0 < d < len2
    function automatic longint edge_param(longint d, longint len2);
        longint r;
        longint q;
        r = d;
        q = 0;
        for (int i = 0; i < 16; i++)
        begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= len2)
            begin
                r = r - len2;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic nbp_pkg::result_t nearest_point(longint px, longint py);
        nbp_pkg::result_t best;
        longint ax, ay, dx, dy, len2, dot, t, qx, qy, ex, ey, dist_sq, best_d;
        int k;
        best = '0;
        best_d = 0;
        for (int j = 0; j < poly_count; j++)
        begin
            k = (j + 1 < poly_count) ? j + 1 : 0;
            ax = poly_x[j];
            ay = poly_y[j];
            dx = poly_x[k] - ax;
            dy = poly_y[k] - ay;
            len2 = dx * dx + dy * dy;
            dot = (px - ax) * dx + (py - ay) * dy;
            if (len2 <= 0 || dot <= 0)
                t = 0;
            else if (dot >= len2)
                t = 65536;
            else
                t = edge_param(dot, len2);
            qx = ax + ((t * dx + 32768) >>> 16);
            qy = ay + ((t * dy + 32768) >>> 16);
            ex = px - qx;
            ey = py - qy;
            dist_sq = ex * ex + ey * ey;
            if (j == 0 || dist_sq < best_d)
            begin
                best_d = dist_sq;
                best.edge_index = j[5:0];
                best.edge_fraction = t[16:0];
                best.proj_x = qx[23:0];
                best.proj_y = qy[23:0];
                best.dist_squared = best_d[49:0];
            end
        end
        best.polygon_empty = (poly_count == 0);
        best.vertex_overflow = poly_overflow;
        return best;
    endfunction

    // update the polygon copy; returns 1 when the item gives a result
    function automatic bit apply_item(logic [1:0] req, int x, int y,
                                      output nbp_pkg::result_t res);
        res = '0;
        case (req)
            nbp_pkg::REQ_START:
            begin
                poly_x[0] = x;
                poly_y[0] = y;
                poly_count = 1;
            end
            nbp_pkg::REQ_APPEND:
            begin
                if (poly_count < MAXV)
                begin
                    poly_x[poly_count] = x;
                    poly_y[poly_count] = y;
                    poly_count++;
                end
                else
                    poly_overflow = 1'b1;
            end
            nbp_pkg::REQ_QUERY:
            begin
                res = nearest_point(x, y);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(logic [1:0] req, int x, int y, bit fixed,
                             nbp_pkg::result_t fixed_res);
        nbp_pkg::result_t res;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {y[23:0], x[23:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (apply_item(req, x, y, res))
        begin
            queries_sent++;
            pending_results.push_back(fixed ? fixed_res : res);
        end
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int rand_coord();
        return $signed($urandom_range(0, 24'hffffff) << 8) >>> 8;
    endfunction

    function automatic int near_coord(int base);
        longint v;
        v = longint'(base) + $signed($urandom_range(0, 4095)) - 2048;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return int'(v);
    endfunction

    // receiver: random stalls, plus one long hold-off once traffic is flowing
    initial
    begin
        int r;
        int hold_left;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent > 300)
            begin
                hold_done = 1'b1;
                hold_left = 4000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if ((items_sent / 200) % 3 == 2)
                    m_axis_tready <= 1'b1;
                else if (r < 3)
                    hold_left = $urandom_range(20, 80);
                else
                    m_axis_tready <= (r < 70);
            end
        end
    end

    always @(posedge clk)
    begin
        nbp_pkg::result_t got;
        nbp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = '0;
            got.edge_index = m_axis_tdata[5:0];
            got.edge_fraction = m_axis_tdata[22:6];
            got.proj_x = m_axis_tdata[46:23];
            got.proj_y = m_axis_tdata[70:47];
            got.dist_squared = m_axis_tdata[120:71];
            got.polygon_empty = m_axis_tuser[0];
            got.vertex_overflow = m_axis_tuser[1];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.edge_index !== want.edge_index
                    || got.edge_fraction !== want.edge_fraction
                    || got.proj_x !== want.proj_x
                    || got.proj_y !== want.proj_y
                    || got.dist_squared !== want.dist_squared
                    || got.polygon_empty !== want.polygon_empty
                    || got.vertex_overflow !== want.vertex_overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected %p, got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        nbp_pkg::result_t r0;
        int n, nq, bx, by, drain;
        int big_polys;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = nbp_pkg::REQ_START;
        poly_count = 0;
        poly_overflow = 1'b0;
        mismatches = 0;
        items_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        big_polys = 0;

        r0 = '0;
        r0.polygon_empty = 1'b1;
        rows.push_back('{nbp_pkg::REQ_QUERY, 123, -45, 1'b1, r0});
        r0 = '0;
        r0.dist_squared = 50;
        rows.push_back('{nbp_pkg::REQ_START, 0, 0, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 5, 5, 1'b1, r0});
        rows.push_back('{nbp_pkg::REQ_START, -8388608, -8388608, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_APPEND, 8388607, -8388608, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_APPEND, 8388607, 8388607, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_APPEND, -8388608, 8388607, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 0, 0, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, -8388608, 8388607, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 8388607, -8388608, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 8388607, 0, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_START, 100, 100, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_APPEND, 100, 100, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_APPEND, 300, 100, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 100, 50, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 200, 200, 1'b0, '0});
        rows.push_back('{REQ_UNUSED, -1, -1, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 500, 100, 1'b0, '0});
        rows.push_back('{nbp_pkg::REQ_QUERY, 0, 0, 1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].req, rows[i].x, rows[i].y, rows[i].fixed, rows[i].res);

        while (items_sent < 1350)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                send_item(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), 1'b0, '0);
                continue;
            end
            n = $urandom_range(0, 99);
            if (n < 88)
                n = $urandom_range(1, 6);
            else if (n < 98 || big_polys >= 6)
                n = $urandom_range(7, 20);
            else
            begin
                n = $urandom_range(64, 70);
                big_polys++;
            end
            bx = $urandom_range(0, 1) ? rand_coord() : $signed($urandom_range(0, 8191)) - 4096;
            by = $urandom_range(0, 1) ? rand_coord() : $signed($urandom_range(0, 8191)) - 4096;
            send_item(nbp_pkg::REQ_START, bx, by, 1'b0, '0);
            for (int v = 1; v < n; v++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(nbp_pkg::REQ_APPEND, rand_coord(), rand_coord(), 1'b0, '0);
                else
                    send_item(nbp_pkg::REQ_APPEND, near_coord(bx), near_coord(by), 1'b0, '0);
            end
            nq = $urandom_range(1, 4);
            for (int q = 0; q < nq; q++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(nbp_pkg::REQ_QUERY, rand_coord(), rand_coord(), 1'b0, '0);
                else
                    send_item(nbp_pkg::REQ_QUERY, near_coord(bx), near_coord(by), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 400000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);

        $display("sent %0d items (%0d queries, %0d large polygons), checked %0d results",
                 items_sent, queries_sent, big_polys, results_seen);
        $display("%0d mismatches, %0d results still expected", mismatches,
                 pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/nbp_pkg.sv
hw/rtl/nbp_queue.sv
hw/rtl/nbp_engine.sv
hw/rtl/nearest_boundary_projection_unit.sv
tb/sv/tb.sv
